// File: rtl/handle_table_refcount_manager_unit_defines.svh
// assertion macros used by the checker file
`ifndef HANDLE_TABLE_REFCOUNT_MANAGER_UNIT_DEFINES_SVH
`define HANDLE_TABLE_REFCOUNT_MANAGER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HTRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define HTRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/htrc_pkg.sv
// shared constants, codes and control types of the handle table unit
`timescale 1ns / 1ps
`default_nettype none
package htrc_pkg;

    localparam int HANDLE_SLOTS_DEF = 64;
    localparam int OBJECT_SLOTS_DEF = 64;
    localparam int COUNT_BITS_DEF   = 16;

    localparam int OP_W      = 3;
    localparam int ID_W      = 6;
    localparam int HV_W      = 16;
    localparam int STATUS_W  = 2;
    localparam int ROBJ_W    = 6;
    localparam int RHANDLE_W = 9;

    localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
    localparam logic [OP_W-1:0] OP_REF    = 3'd1;
    localparam logic [OP_W-1:0] OP_DEREF  = 3'd2;
    localparam logic [OP_W-1:0] OP_PERM   = 3'd3;
    localparam logic [OP_W-1:0] OP_OPEN   = 3'd4;
    localparam logic [OP_W-1:0] OP_REFH   = 3'd5;
    localparam logic [OP_W-1:0] OP_CLOSE  = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_LIVE   = 2'd3;

    typedef struct packed {
        logic load;
        logic hread;
        logic oread;
        logic commit;
    } htrc_cmd_t;

endpackage
`default_nettype wire

// File: rtl/handle_table_refcount_manager_unit.sv
// top level of the reference-counted handle table
// an accepted item passes the handle read, object read and execute states before its result is registered
// no new item is taken until execute is done, since the object table is read, modified and written per item
// execute holds while the previous result is still stalled at the output
// reset clears the live and handle-used bits at once; no clearing pass, ready right after reset
`timescale 1ns / 1ps
`default_nettype none
module handle_table_refcount_manager_unit
    import htrc_pkg::*;
#(
    parameter int HANDLE_SLOTS = HANDLE_SLOTS_DEF,
    parameter int OBJECT_SLOTS = OBJECT_SLOTS_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [OP_W-1:0]      operation,
    input  wire logic [ID_W-1:0]      object_id,
    input  wire logic [HV_W-1:0]      handle_value,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [STATUS_W-1:0]  status,
    output logic      [ROBJ_W-1:0]    result_object,
    output logic      [RHANDLE_W-1:0] result_handle,
    output logic                      object_freed
);

    htrc_cmd_t cmd;

    htrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    htrc_datapath #(
        .HANDLE_SLOTS (HANDLE_SLOTS),
        .OBJECT_SLOTS (OBJECT_SLOTS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .operation     (operation),
        .object_id     (object_id),
        .handle_value  (handle_value),
        .status        (status),
        .result_object (result_object),
        .result_handle (result_handle),
        .object_freed  (object_freed)
    );

endmodule
`default_nettype wire

// File: rtl/htrc_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module htrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/htrc_ffs.sv
// two-stage registered search for the lowest set bit of a vector
`timescale 1ns / 1ps
`default_nettype none
module htrc_ffs #(
    parameter int N = 64,
    localparam int IDX_W = (N > 1) ? $clog2(N) : 1
) (
    input  wire logic             clk,
    input  wire logic [N-1:0]     free,
    output logic                  any,
    output logic      [IDX_W-1:0] first
);

    localparam int GROUP = 8;
    localparam int NG    = (N + GROUP - 1) / GROUP;
    localparam int GW    = (NG > 1) ? $clog2(NG) : 1;

    logic [NG*GROUP-1:0] pad;
    logic [NG-1:0]       grp_any_next;
    logic [2:0]          grp_off_next [NG];
    logic [NG-1:0]       grp_any_reg;
    logic [2:0]          grp_off_reg [NG];
    logic [GW-1:0]       sel;
    logic                any_next;
    logic [GW+2:0]       full;
    logic [IDX_W+GW+2:0] full_ext;
    logic                any_reg;
    logic [IDX_W-1:0]    first_reg;

    assign pad = {{(NG*GROUP-N){1'b0}}, free};

    // stage one: per group of eight
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_any_next[g] = |pad[g*GROUP +: GROUP];
            grp_off_next[g] = 3'd0;
            for (int k = GROUP - 1; k >= 0; k--)
            begin
                if (pad[g*GROUP + k])
                begin
                    grp_off_next[g] = 3'(k);
                end
            end
        end
    end

    // stage two: lowest group with a free entry
    always_comb
    begin
        sel = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                sel = GW'(g);
            end
        end
        any_next = |grp_any_reg;
        full     = {sel, grp_off_reg[sel]};
        full_ext = {{IDX_W{1'b0}}, full};
    end

    always_ff @(posedge clk)
    begin
        grp_any_reg <= grp_any_next;
        grp_off_reg <= grp_off_next;
        any_reg     <= any_next;
        first_reg   <= full_ext[IDX_W-1:0];
    end

    assign any   = any_reg;
    assign first = first_reg;

endmodule
`default_nettype wire

// File: rtl/htrc_ctrl.sv
// sequencer: accept, handle read, object read, execute and output valid
`timescale 1ns / 1ps
`default_nettype none
module htrc_ctrl
    import htrc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    output htrc_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_HREAD = 2'd1;
    localparam logic [1:0] S_OREAD = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       commit;

    // execute waits only while the previous result is still held
    assign commit = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_HREAD;
                end
            end
            S_HREAD: state_next = S_OREAD;
            S_OREAD: state_next = S_EXEC;
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign cmd.load   = (state_reg == S_IDLE) && in_valid;
    assign cmd.hread  = (state_reg == S_HREAD);
    assign cmd.oread  = (state_reg == S_OREAD);
    assign cmd.commit = commit;

endmodule
`default_nettype wire

// File: rtl/htrc_datapath.sv
// object and handle tables, free-slot searches and the operation logic
`timescale 1ns / 1ps
`default_nettype none
module htrc_datapath
    import htrc_pkg::*;
#(
    parameter int HANDLE_SLOTS = HANDLE_SLOTS_DEF,
    parameter int OBJECT_SLOTS = OBJECT_SLOTS_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire htrc_cmd_t            cmd,
    input  wire logic [OP_W-1:0]      operation,
    input  wire logic [ID_W-1:0]      object_id,
    input  wire logic [HV_W-1:0]      handle_value,
    output logic      [STATUS_W-1:0]  status,
    output logic      [ROBJ_W-1:0]    result_object,
    output logic      [RHANDLE_W-1:0] result_handle,
    output logic                      object_freed
);

    localparam int OIDX_W = (OBJECT_SLOTS > 1) ? $clog2(OBJECT_SLOTS) : 1;
    localparam int HIDX_W = (HANDLE_SLOTS > 1) ? $clog2(HANDLE_SLOTS) : 1;
    localparam int ROW_W  = 2 * COUNT_BITS + 1;

    // latched item
    logic [OP_W-1:0] op_reg;
    logic [ID_W-1:0] id_reg;
    logic [HV_W-1:0] hv_reg;

    // valid bits
    logic [OBJECT_SLOTS-1:0] live_reg;
    logic [OBJECT_SLOTS-1:0] live_next;
    logic [HANDLE_SLOTS-1:0] used_reg;
    logic [HANDLE_SLOTS-1:0] used_next;

    // result register
    logic [STATUS_W-1:0]  status_reg;
    logic [ROBJ_W-1:0]    robj_reg;
    logic [RHANDLE_W-1:0] rhandle_reg;
    logic                 freed_reg;

    // decode
    logic [OIDX_W+ID_W-1:0] id_ext;
    logic [OIDX_W-1:0]      oidx;
    logic                   id_ok;
    logic [HV_W-3:0]        hq;
    logic [HIDX_W-1:0]      hidx;
    logic                   hidx_ok;
    logic                   by_handle;

    // tables
    logic [OIDX_W-1:0] hram_rdata;
    logic              hram_we;
    logic [HIDX_W-1:0] hram_waddr;
    logic [OIDX_W-1:0] hram_wdata;
    logic [ROW_W-1:0]  oram_rdata;
    logic              oram_we;
    logic [OIDX_W-1:0] oram_waddr;
    logic [ROW_W-1:0]  oram_wdata;
    logic [OIDX_W-1:0] oram_raddr;

    // free-slot searches
    logic              obj_any;
    logic [OIDX_W-1:0] obj_first;
    logic              h_any;
    logic [HIDX_W-1:0] h_first;

    // row fields and count updates
    logic [COUNT_BITS-1:0] cur_ref;
    logic [COUNT_BITS-1:0] cur_hc;
    logic                  cur_perm;
    logic [COUNT_BITS-1:0] ref_inc;
    logic [COUNT_BITS-1:0] ref_dec;
    logic [COUNT_BITS-1:0] hc_inc;
    logic [COUNT_BITS-1:0] hc_dec;

    logic [OIDX_W+ROBJ_W-1:0]    first_ext;
    logic [OIDX_W+ROBJ_W-1:0]    hobj_ext;
    logic [HIDX_W:0]             hslot_p1;
    logic [HIDX_W+2:0]           rh_full;
    logic [HIDX_W+RHANDLE_W+2:0] rh_ext;

    // execute outputs
    logic [STATUS_W-1:0]  st;
    logic [ROBJ_W-1:0]    robj;
    logic [RHANDLE_W-1:0] rh;
    logic                 fr;
    logic                 o_we;
    logic [OIDX_W-1:0]    o_waddr;
    logic [ROW_W-1:0]     o_wdata;
    logic                 h_we;
    logic                 live_set;
    logic                 live_clr;
    logic [OIDX_W-1:0]    live_idx;
    logic                 used_set;
    logic                 used_clr;
    logic [HIDX_W-1:0]    used_idx;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= operation;
            id_reg <= object_id;
            hv_reg <= handle_value;
        end
        if (cmd.commit)
        begin
            status_reg  <= st;
            robj_reg    <= robj;
            rhandle_reg <= rh;
            freed_reg   <= fr;
        end
    end

    assign id_ext  = {{OIDX_W{1'b0}}, id_reg};
    assign oidx    = id_ext[OIDX_W-1:0];
    assign id_ok   = ({5'b0, id_reg} < 11'(OBJECT_SLOTS)) && live_reg[oidx];

    // handle value = (slot + 1) * 4
    assign hq      = hv_reg[HV_W-1:2] - 1'b1;
    assign hidx    = hq[HIDX_W-1:0];
    assign hidx_ok = (hv_reg != '0) && (hv_reg[1:0] == 2'b00)
                     && (hq < (HV_W-2)'(HANDLE_SLOTS)) && used_reg[hidx];

    assign by_handle  = (op_reg == OP_REFH) || (op_reg == OP_CLOSE);
    assign oram_raddr = by_handle ? hram_rdata : oidx;

    htrc_ram #(
        .WIDTH (OIDX_W),
        .DEPTH (HANDLE_SLOTS)
    ) u_hram (
        .clk   (clk),
        .we    (hram_we),
        .waddr (hram_waddr),
        .wdata (hram_wdata),
        .re    (cmd.hread),
        .raddr (hidx),
        .rdata (hram_rdata)
    );

    htrc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (OBJECT_SLOTS)
    ) u_oram (
        .clk   (clk),
        .we    (oram_we),
        .waddr (oram_waddr),
        .wdata (oram_wdata),
        .re    (cmd.oread),
        .raddr (oram_raddr),
        .rdata (oram_rdata)
    );

    htrc_ffs #(
        .N (OBJECT_SLOTS)
    ) u_obj_ffs (
        .clk   (clk),
        .free  (~live_reg),
        .any   (obj_any),
        .first (obj_first)
    );

    htrc_ffs #(
        .N (HANDLE_SLOTS)
    ) u_h_ffs (
        .clk   (clk),
        .free  (~used_reg),
        .any   (h_any),
        .first (h_first)
    );

    assign cur_ref  = oram_rdata[COUNT_BITS-1:0];
    assign cur_hc   = oram_rdata[2*COUNT_BITS-1:COUNT_BITS];
    assign cur_perm = oram_rdata[ROW_W-1];

    // counts saturate at all ones and stop at zero
    assign ref_inc = (cur_ref == {COUNT_BITS{1'b1}}) ? cur_ref : cur_ref + 1'b1;
    assign ref_dec = (cur_ref == '0) ? cur_ref : cur_ref - 1'b1;
    assign hc_inc  = (cur_hc == {COUNT_BITS{1'b1}}) ? cur_hc : cur_hc + 1'b1;
    assign hc_dec  = (cur_hc == '0) ? cur_hc : cur_hc - 1'b1;

    assign first_ext = {{ROBJ_W{1'b0}}, obj_first};
    assign hobj_ext  = {{ROBJ_W{1'b0}}, hram_rdata};
    assign hslot_p1  = {1'b0, h_first} + 1'b1;
    assign rh_full   = {hslot_p1, 2'b00};
    assign rh_ext    = {{RHANDLE_W{1'b0}}, rh_full};

    always_comb
    begin
        st       = ST_OK;
        robj     = '0;
        rh       = '0;
        fr       = 1'b0;
        o_we     = 1'b0;
        o_waddr  = oidx;
        o_wdata  = oram_rdata;
        h_we     = 1'b0;
        live_set = 1'b0;
        live_clr = 1'b0;
        live_idx = oidx;
        used_set = 1'b0;
        used_clr = 1'b0;
        used_idx = hidx;
        case (op_reg)
            OP_CREATE:
            begin
                if (obj_any)
                begin
                    o_we     = 1'b1;
                    o_waddr  = obj_first;
                    o_wdata  = {1'b0, {COUNT_BITS{1'b0}}, COUNT_BITS'(1)};
                    live_set = 1'b1;
                    live_idx = obj_first;
                    robj     = first_ext[ROBJ_W-1:0];
                end
                else
                begin
                    st = ST_NO_SLOT;
                end
            end
            OP_REF:
            begin
                if (!id_ok)
                begin
                    st = ST_NOT_LIVE;
                end
                else
                begin
                    o_we    = 1'b1;
                    o_wdata = {cur_perm, cur_hc, ref_inc};
                end
            end
            OP_DEREF:
            begin
                if (!id_ok)
                begin
                    st = ST_NOT_LIVE;
                end
                else
                begin
                    o_we     = 1'b1;
                    o_wdata  = {cur_perm, cur_hc, ref_dec};
                    fr       = !cur_perm && (ref_dec == '0) && (cur_hc == '0);
                    live_clr = fr;
                end
            end
            OP_PERM:
            begin
                if (!id_ok)
                begin
                    st = ST_NOT_LIVE;
                end
                else
                begin
                    o_we    = 1'b1;
                    o_wdata = {1'b1, cur_hc, cur_ref};
                end
            end
            OP_OPEN:
            begin
                if (!id_ok)
                begin
                    st = ST_NOT_LIVE;
                end
                else if (!h_any)
                begin
                    st = ST_NO_SLOT;
                end
                else
                begin
                    h_we     = 1'b1;
                    used_set = 1'b1;
                    used_idx = h_first;
                    o_we     = 1'b1;
                    o_wdata  = {cur_perm, hc_inc, ref_inc};
                    rh       = rh_ext[RHANDLE_W-1:0];
                end
            end
            OP_REFH, OP_CLOSE:
            begin
                if (!hidx_ok)
                begin
                    st = ST_BAD_HANDLE;
                end
                else
                begin
                    robj     = hobj_ext[ROBJ_W-1:0];
                    used_clr = (op_reg == OP_CLOSE);
                    o_waddr  = hram_rdata;
                    live_idx = hram_rdata;
                    // stale handle: its object was freed underneath it
                    if (!live_reg[hram_rdata])
                    begin
                        st = ST_NOT_LIVE;
                    end
                    else if (op_reg == OP_REFH)
                    begin
                        o_we    = 1'b1;
                        o_wdata = {cur_perm, cur_hc, ref_inc};
                    end
                    else
                    begin
                        o_we     = 1'b1;
                        o_wdata  = {cur_perm, hc_dec, ref_dec};
                        fr       = !cur_perm && (ref_dec == '0) && (hc_dec == '0);
                        live_clr = fr;
                    end
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    assign oram_we    = cmd.commit && o_we;
    assign oram_waddr = o_waddr;
    assign oram_wdata = o_wdata;
    assign hram_we    = cmd.commit && h_we;
    assign hram_waddr = h_first;
    assign hram_wdata = oidx;

    always_comb
    begin
        live_next = live_reg;
        used_next = used_reg;
        if (cmd.commit)
        begin
            if (live_set)
            begin
                live_next[live_idx] = 1'b1;
            end
            if (live_clr)
            begin
                live_next[live_idx] = 1'b0;
            end
            if (used_set)
            begin
                used_next[used_idx] = 1'b1;
            end
            if (used_clr)
            begin
                used_next[used_idx] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            used_reg <= '0;
        end
        else
        begin
            live_reg <= live_next;
            used_reg <= used_next;
        end
    end

    assign status        = status_reg;
    assign result_object = robj_reg;
    assign result_handle = rhandle_reg;
    assign object_freed  = freed_reg;

endmodule
`default_nettype wire

// File: rtl/htrc_check.sv
// port-level checker for the handle table unit and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "handle_table_refcount_manager_unit_defines.svh"
module htrc_check
    import htrc_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_stall,
    input wire logic [OP_W-1:0]      operation,
    input wire logic [ID_W-1:0]      object_id,
    input wire logic [HV_W-1:0]      handle_value,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic [STATUS_W-1:0]  status,
    input wire logic [ROBJ_W-1:0]    result_object,
    input wire logic [RHANDLE_W-1:0] result_handle,
    input wire logic                 object_freed
);

    `HTRC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

    `HTRC_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall, "second item taken while one is in work")

    `HTRC_ASSERT_NOW(a_handle_ok, clk, rst_n, out_valid && (result_handle != '0), (status == ST_OK) && (result_handle[1:0] == 2'b00) && !object_freed, "opened handle with bad status or form")

    `HTRC_ASSERT_NOW(a_freed_ok, clk, rst_n, out_valid && object_freed, status == ST_OK, "object freed on a failed item")

endmodule

bind handle_table_refcount_manager_unit htrc_check u_htrc_check (.*);
`default_nettype wire

// File: tb/sv/handle_table_refcount_manager_unit_test.sv
// self-checking testbench of the reference-counted handle table unit
`timescale 1ns / 1ps
module handle_table_refcount_manager_unit_test;
    import htrc_pkg::*;

    localparam int       OBJ_SLOTS   = OBJECT_SLOTS_DEF;
    localparam int       HND_SLOTS   = HANDLE_SLOTS_DEF;
    localparam bit [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int       RANDOM_ITEMS = 1500;
    localparam longint   CYCLE_LIMIT  = 2000000;
    localparam int       PRINT_CAP    = 40;

    typedef struct packed {
        logic [STATUS_W-1:0]  stat;
        logic [ROBJ_W-1:0]    obj;
        logic [RHANDLE_W-1:0] hnd;
        logic                 freed;
    } outcome_t;

    class refcount_scoreboard;
        bit                      handle_used[HND_SLOTS];
        bit [ID_W-1:0]           handle_owner[HND_SLOTS];
        bit                      live[OBJ_SLOTS];
        bit [COUNT_BITS_DEF-1:0] refs_held[OBJ_SLOTS];
        bit [COUNT_BITS_DEF-1:0] hnd_count[OBJ_SLOTS];
        bit                      permanent[OBJ_SLOTS];
        outcome_t                pending_outcomes[$];
        outcome_t                last_outcome;
        int                      failures;
        int                      results_seen;

        function bit [COUNT_BITS_DEF-1:0] count_up(bit [COUNT_BITS_DEF-1:0] v);
            return (v == COUNT_MAX) ? v : v + 1'b1;
        endfunction

        function bit [COUNT_BITS_DEF-1:0] count_down(bit [COUNT_BITS_DEF-1:0] v);
            return (v == 0) ? v : v - 1'b1;
        endfunction

        // drops the object once nothing holds it
        function bit release_if_unheld(int o);
            if (permanent[o] || refs_held[o] != 0 || hnd_count[o] != 0)
                return 1'b0;
            live[o] = 1'b0;
            return 1'b1;
        endfunction

        function outcome_t apply_operation(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                           logic [HV_W-1:0] hv);
            outcome_t r;
            int       o;
            int       hi;
            bit       found;
            r = '0;
            o = int'(id);
            found = 1'b0;
            case (op)
                OP_CREATE:
                begin
                    r.stat = ST_NO_SLOT;
                    for (int i = 0; i < OBJ_SLOTS && !found; i++)
                    begin
                        if (!live[i])
                        begin
                            live[i] = 1'b1;
                            refs_held[i] = COUNT_BITS_DEF'(1);
                            hnd_count[i] = '0;
                            permanent[i] = 1'b0;
                            r.stat = ST_OK;
                            r.obj = ROBJ_W'(i);
                            found = 1'b1;
                        end
                    end
                end
                OP_REF, OP_DEREF, OP_PERM, OP_OPEN:
                begin
                    if (!live[o])
                        r.stat = ST_NOT_LIVE;
                    else if (op == OP_REF)
                        refs_held[o] = count_up(refs_held[o]);
                    else if (op == OP_DEREF)
                    begin
                        refs_held[o] = count_down(refs_held[o]);
                        r.freed = release_if_unheld(o);
                    end
                    else if (op == OP_PERM)
                        permanent[o] = 1'b1;
                    else
                    begin
                        r.stat = ST_NO_SLOT;
                        for (int i = 0; i < HND_SLOTS && !found; i++)
                        begin
                            if (!handle_used[i])
                            begin
                                handle_used[i] = 1'b1;
                                handle_owner[i] = ID_W'(o);
                                hnd_count[o] = count_up(hnd_count[o]);
                                refs_held[o] = count_up(refs_held[o]);
                                r.stat = ST_OK;
                                r.hnd = RHANDLE_W'((i + 1) * 4);
                                found = 1'b1;
                            end
                        end
                    end
                end
                OP_REFH, OP_CLOSE:
                begin
                    hi = int'(hv >> 2) - 1;
                    if (hv == 0 || hv[1:0] != 2'b00 || hi >= HND_SLOTS || !handle_used[hi])
                        r.stat = ST_BAD_HANDLE;
                    else
                    begin
                        o = int'(handle_owner[hi]);
                        r.obj = ROBJ_W'(o);
                        if (op == OP_CLOSE)
                            handle_used[hi] = 1'b0;
                        // stale handle: owner was freed while the handle still named it
                        if (!live[o])
                            r.stat = ST_NOT_LIVE;
                        else if (op == OP_REFH)
                            refs_held[o] = count_up(refs_held[o]);
                        else
                        begin
                            hnd_count[o] = count_down(hnd_count[o]);
                            refs_held[o] = count_down(refs_held[o]);
                            r.freed = release_if_unheld(o);
                        end
                    end
                end
                default:
                    r = '0;
            endcase
            return r;
        endfunction

        function void note_input(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                 logic [HV_W-1:0] hv);
            last_outcome = apply_operation(op, id, hv);
            pending_outcomes.push_back(last_outcome);
        endfunction

        task report(string msg);
            failures++;
            if (failures <= PRINT_CAP)
                $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
        endtask

        task check_result(outcome_t got);
            outcome_t want;
            results_seen++;
            if (pending_outcomes.size() == 0)
            begin
                report("result with no item waiting");
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.stat !== want.stat)
                report($sformatf("status %0d, expected %0d", got.stat, want.stat));
            if (got.obj !== want.obj)
                report($sformatf("result_object %0d, expected %0d", got.obj, want.obj));
            if (got.hnd !== want.hnd)
                report($sformatf("result_handle %0d, expected %0d", got.hnd, want.hnd));
            if (got.freed !== want.freed)
                report($sformatf("object_freed %0b, expected %0b", got.freed, want.freed));
        endtask

        function logic [ID_W-1:0] pick_live_object();
            int ids[$];
            for (int i = 0; i < OBJ_SLOTS; i++)
                if (live[i])
                    ids.push_back(i);
            if (ids.size() == 0)
                return ID_W'($urandom_range(0, OBJ_SLOTS - 1));
            return ID_W'(ids[$urandom_range(0, ids.size() - 1)]);
        endfunction

        function logic [HV_W-1:0] pick_open_handle();
            int hs[$];
            for (int i = 0; i < HND_SLOTS; i++)
                if (handle_used[i])
                    hs.push_back((i + 1) * 4);
            if (hs.size() == 0)
                return HV_W'($urandom_range(1, HND_SLOTS) * 4);
            return HV_W'(hs[$urandom_range(0, hs.size() - 1)]);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [OP_W-1:0]      operation;
    logic [ID_W-1:0]      object_id;
    logic [HV_W-1:0]      handle_value;
    logic                 out_valid;
    logic                 out_stall;
    logic [STATUS_W-1:0]  status;
    logic [ROBJ_W-1:0]    result_object;
    logic [RHANDLE_W-1:0] result_handle;
    logic                 object_freed;

    refcount_scoreboard sb;
    bit                 gaps_on;
    longint             cycles;

    handle_table_refcount_manager_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .object_id     (object_id),
        .handle_value  (handle_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .result_object (result_object),
        .result_handle (result_handle),
        .object_freed  (object_freed)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task issue_operation(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [HV_W-1:0] hv);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation = op;
        object_id = id;
        handle_value = hv;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_input(op, id, hv);
    endtask

    task run_mixed(int n);
        int pick;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 14)
                issue_operation(OP_CREATE, ID_W'($urandom), HV_W'($urandom));
            else if (pick < 28)
                issue_operation(OP_REF, sb.pick_live_object(), HV_W'($urandom));
            else if (pick < 46)
                issue_operation(OP_DEREF, sb.pick_live_object(), HV_W'($urandom));
            else if (pick < 48)
                issue_operation(OP_PERM, sb.pick_live_object(), HV_W'($urandom));
            else if (pick < 62)
                issue_operation(OP_OPEN, sb.pick_live_object(), HV_W'($urandom));
            else if (pick < 76)
                issue_operation(OP_REFH, ID_W'($urandom), sb.pick_open_handle());
            else if (pick < 92)
                issue_operation(OP_CLOSE, ID_W'($urandom), sb.pick_open_handle());
            else if (pick < 96)
                issue_operation(OP_W'($urandom_range(OP_REF, OP_OPEN)), ID_W'($urandom),
                                HV_W'($urandom));
            else
                issue_operation(OP_W'($urandom_range(OP_REFH, OP_CLOSE)), ID_W'($urandom),
                                HV_W'($urandom));
        end
    endtask

    // result side: random stall before each result, then sample at the rising edge
    initial
    begin
        outcome_t got;
        int       hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            hold = gaps_on ? $urandom_range(0, 5) : 0;
            if (hold > 0)
            begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
            got.stat = status;
            got.obj = result_object;
            got.hnd = result_handle;
            got.freed = object_freed;
            sb.check_result(got);
        end
    end

    initial
    begin
        int kind;
        int n;
        int sent;
        sb = new;
        clk = 1'b0;
        cycles = 0;
        gaps_on = 1'b1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_CREATE;
        object_id = '0;
        handle_value = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // malformed and empty handles, objects that are not live
        issue_operation(OP_REFH, 6'd0, 16'd0);
        issue_operation(OP_CLOSE, 6'd0, 16'd3);
        issue_operation(OP_REFH, 6'd63, 16'hFFFC);
        issue_operation(OP_CLOSE, 6'd0, 16'hFFFF);
        issue_operation(OP_REFH, 6'd0, 16'd4);
        issue_operation(OP_REFH, 6'd0, 16'd260);
        issue_operation(OP_REF, 6'd63, 16'd0);
        issue_operation(OP_DEREF, 6'd0, 16'd0);
        issue_operation(OP_PERM, 6'd5, 16'd0);
        issue_operation(OP_OPEN, 6'd0, 16'd0);
        // normal life of two objects
        issue_operation(OP_CREATE, 6'd63, 16'hFFFF);
        issue_operation(OP_CREATE, 6'd0, 16'd0);
        issue_operation(OP_OPEN, 6'd0, 16'd0);
        issue_operation(OP_REFH, 6'd0, 16'd4);
        issue_operation(OP_REF, 6'd0, 16'd0);
        issue_operation(OP_DEREF, 6'd1, 16'd0);
        issue_operation(OP_CREATE, 6'd0, 16'd0);
        issue_operation(OP_PERM, 6'd1, 16'd0);
        issue_operation(OP_DEREF, 6'd1, 16'd0);
        issue_operation(OP_CLOSE, 6'd0, 16'd4);
        issue_operation(OP_CLOSE, 6'd0, 16'd4);
        issue_operation(OP_DEREF, 6'd0, 16'd0);
        issue_operation(OP_DEREF, 6'd0, 16'd0);
        issue_operation(OP_DEREF, 6'd0, 16'd0);
        issue_operation(OP_UNUSED, 6'd63, 16'hFFFF);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            case (kind)
                0:
                begin
                    // long create runs fill the object table
                    n = $urandom_range(1, OBJ_SLOTS + 6);
                    repeat (n)
                        issue_operation(OP_CREATE, ID_W'($urandom), HV_W'($urandom));
                end
                1:
                begin
                    // long open runs fill the handle table
                    n = $urandom_range(1, HND_SLOTS + 6);
                    repeat (n)
                        issue_operation(OP_OPEN, sb.pick_live_object(), HV_W'($urandom));
                end
                2:
                begin
                    n = $urandom_range(10, 80);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 1))
                            issue_operation(OP_CLOSE, ID_W'($urandom), sb.pick_open_handle());
                        else
                            issue_operation(OP_DEREF, sb.pick_live_object(), HV_W'($urandom));
                    end
                end
                3:
                begin
                    n = $urandom_range(4, 20);
                    repeat (n)
                        issue_operation(OP_W'($urandom), ID_W'($urandom), HV_W'($urandom));
                end
                default:
                begin
                    n = $urandom_range(4, 20);
                    run_mixed(n);
                end
            endcase
            sent += n;
        end

        @(negedge clk);
        in_valid = 1'b0;
        gaps_on = 1'b0;
        while (sb.pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
